### src/sgdu_pkg.sv
package sgdu_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int ADAPT_EPSILON_DEF = 1;

  localparam int VAL_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // rmsprop decay 0.9 / 0.1 in Q0.16
  localparam logic [15:0] RMS_KEEP = 16'd58982;
  localparam logic [15:0] RMS_NEW  = 16'd6554;

  localparam logic [15:0] LEARN_RATE_RST = 16'd655;
  localparam logic [15:0] BATCH_RST      = 16'd1;
  // 655 * 2^16 / 1
  localparam logic [31:0] STEP_RST       = 32'd42926080;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARN_RATE    = 3'd0,
    CFG_BATCH_COUNT   = 3'd1,
    CFG_REG_STRENGTH  = 3'd2,
    CFG_REG_MODE      = 3'd3,
    CFG_MOMENTUM_GAIN = 3'd4,
    CFG_ACCUM_MODE    = 3'd5,
    CFG_ADAPT_RATE    = 3'd6
  } cfg_index_t;

  typedef enum logic [1:0] {
    REG_NONE = 2'd0,
    REG_L1   = 2'd1,
    REG_L2   = 2'd2
  } reg_mode_t;

  typedef enum logic [1:0] {
    ACC_NONE    = 2'd0,
    ACC_ADAGRAD = 2'd1,
    ACC_RMSPROP = 2'd2
  } accum_mode_t;

endpackage

### src/sgdu_in_if.sv
interface sgdu_in_if;
  import sgdu_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [VAL_W-1:0] weight_value;
  logic signed [VAL_W-1:0] grad_sum;
  logic signed [VAL_W-1:0] prev_grad;
  logic        [VAL_W-1:0] sq_accum;
  logic                    last_element;

  modport source (output valid, action, weight_value, grad_sum, prev_grad, sq_accum,
                  last_element, input ready);
  modport sink (input valid, action, weight_value, grad_sum, prev_grad, sq_accum,
                last_element, output ready);
endinterface

### src/sgdu_out_if.sv
interface sgdu_out_if;
  import sgdu_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] new_value;
  logic        [VAL_W-1:0] new_sq_accum;
  logic                    last_out;

  modport source (output valid, new_value, new_sq_accum, last_out, input ready);
  modport sink (input valid, new_value, new_sq_accum, last_out, output ready);
endinterface

### src/sgdu_cfg_if.sv
interface sgdu_cfg_if;
  import sgdu_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/sgdu_rate_pipe.sv
// Pipelined floor square root (one root bit a stage) followed by a
// pipelined restoring divide (one quotient bit a stage). Sideband rides along.
module sgdu_rate_pipe #(
  parameter int XW   = 50,
  parameter int DW   = 48,
  parameter int SB_W = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [XW-1:0]   in_x,
  input  logic [DW-1:0]   in_n,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output logic [DW-1:0]   out_q,
  output logic [SB_W-1:0] out_sb
);

  localparam int RW = XW / 2;

  logic            sq_v_r    [RW];
  logic [XW-1:0]   sq_x_r    [RW];
  logic [RW+1:0]   sq_rem_r  [RW];
  logic [RW-1:0]   sq_root_r [RW];
  logic [DW-1:0]   sq_n_r    [RW];
  logic [SB_W-1:0] sq_sb_r   [RW];

  logic            dv_v_r   [DW];
  logic [RW-1:0]   dv_rem_r [DW];
  logic [RW-1:0]   dv_s_r   [DW];
  logic [DW-1:0]   dv_n_r   [DW];
  logic [DW-1:0]   dv_q_r   [DW];
  logic [SB_W-1:0] dv_sb_r  [DW];

  genvar k;
  generate
    for (k = 0; k < RW; k++) begin : g_sqrt
      logic            src_v;
      logic [XW-1:0]   src_x;
      logic [RW+1:0]   src_rem;
      logic [RW-1:0]   src_root;
      logic [DW-1:0]   src_n;
      logic [SB_W-1:0] src_sb;
      logic [RW+3:0]   rem_sh;
      logic [RW+3:0]   trial;
      logic            ge;

      if (k == 0) begin : g_first
        assign src_v    = in_valid;
        assign src_x    = in_x;
        assign src_rem  = '0;
        assign src_root = '0;
        assign src_n    = in_n;
        assign src_sb   = in_sb;
      end else begin : g_next
        assign src_v    = sq_v_r[k-1];
        assign src_x    = sq_x_r[k-1];
        assign src_rem  = sq_rem_r[k-1];
        assign src_root = sq_root_r[k-1];
        assign src_n    = sq_n_r[k-1];
        assign src_sb   = sq_sb_r[k-1];
      end

      assign rem_sh = {src_rem, src_x[XW-1 -: 2]};
      assign trial  = {2'b00, src_root, 2'b01};
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sq_v_r[k] <= 1'b0;
        end else if (en) begin
          sq_v_r[k] <= src_v;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          sq_x_r[k]    <= src_x << 2;
          sq_rem_r[k]  <= ge ? (RW+2)'(rem_sh - trial) : rem_sh[RW+1:0];
          sq_root_r[k] <= {src_root[RW-2:0], ge};
          sq_n_r[k]    <= src_n;
          sq_sb_r[k]   <= src_sb;
        end
      end
    end

    for (k = 0; k < DW; k++) begin : g_div
      logic            src_v;
      logic [RW-1:0]   src_rem;
      logic [RW-1:0]   src_s;
      logic [DW-1:0]   src_n;
      logic [DW-1:0]   src_q;
      logic [SB_W-1:0] src_sb;
      logic [RW:0]     trial;
      logic            ge;

      if (k == 0) begin : g_first
        assign src_v   = sq_v_r[RW-1];
        assign src_rem = '0;
        assign src_s   = sq_root_r[RW-1];
        assign src_n   = sq_n_r[RW-1];
        assign src_q   = '0;
        assign src_sb  = sq_sb_r[RW-1];
      end else begin : g_next
        assign src_v   = dv_v_r[k-1];
        assign src_rem = dv_rem_r[k-1];
        assign src_s   = dv_s_r[k-1];
        assign src_n   = dv_n_r[k-1];
        assign src_q   = dv_q_r[k-1];
        assign src_sb  = dv_sb_r[k-1];
      end

      assign trial = {src_rem, src_n[DW-1]};
      assign ge    = trial >= {1'b0, src_s};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_v_r[k] <= 1'b0;
        end else if (en) begin
          dv_v_r[k] <= src_v;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem_r[k] <= ge ? RW'(trial - {1'b0, src_s}) : trial[RW-1:0];
          dv_s_r[k]   <= src_s;
          dv_n_r[k]   <= src_n << 1;
          dv_q_r[k]   <= {src_q[DW-2:0], ge};
          dv_sb_r[k]  <= src_sb;
        end
      end
    end
  endgenerate

  assign out_valid = dv_v_r[DW-1];
  assign out_q     = dv_q_r[DW-1];
  assign out_sb    = dv_sb_r[DW-1];

endmodule

### src/sgd_adaptive_weight_update.sv
// SGD parameter update with momentum, L1/L2 regularisation and an
// adagrad / rmsprop accumulator, one Q(32-F).F element per word. The block
// takes one word every cycle unless stalled and gives one result word per
// input word, in order. The pipe depth is set by the per-element
// rate path: a square root pipe resolving one root bit a stage, then a
// divider resolving one quotient bit a stage. Every stage moves together, so
// a stall on the result side holds the whole pipe. A write to any register
// starts a serial division of learn_rate by batch_count; while it
// runs neither new words nor further writes are taken.
module sgd_adaptive_weight_update #(
  parameter int FRAC_BITS     = sgdu_pkg::FRAC_BITS_DEF,
  parameter int ADAPT_EPSILON = sgdu_pkg::ADAPT_EPSILON_DEF
) (
  input logic       clk,
  input logic       rst_n,
  sgdu_in_if.sink   in_ch,
  sgdu_out_if.source out_ch,
  sgdu_cfg_if.sink  cfg_ch
);
  import sgdu_pkg::*;

  localparam int F      = FRAC_BITS;
  localparam int XW     = ((34 + F) / 2) * 2;  // sqrt operand, (acc+eps) << F
  localparam int DW     = 32 + F;              // dividend, step << F
  localparam int HI_W   = (F + 1) / 2;         // rate bits above 32
  localparam int RATE_W = 32 + HI_W;
  localparam int TW     = 32 + HI_W;           // product term magnitude
  localparam int SW     = TW + 4;              // exact signed sum
  localparam int PRW    = RATE_W + 16;         // rate * lambda
  localparam int L1W    = PRW - (48 - F);

  typedef struct packed {
    logic          bias;
    logic [31:0]   w;
    logic          gneg;
    logic [31:0]   gmag;
    logic signed [32:0] mom;
    logic [31:0]   acc;
    logic          last;
  } rp_sb_t;

  // ---------------------------------------------------------------- config
  logic [15:0] learn_rate_r, batch_count_r, reg_strength_r, momentum_gain_r;
  logic [1:0]  reg_mode_r, accum_mode_r;
  logic        adapt_rate_r;
  logic        cfg_fire, cfg_busy;
  logic        div_load_r, div_run_r;

  assign cfg_busy     = div_load_r || div_run_r;
  assign cfg_ch.ready = !cfg_busy;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r    <= LEARN_RATE_RST;
      batch_count_r   <= BATCH_RST;
      reg_strength_r  <= '0;
      reg_mode_r      <= REG_NONE;
      momentum_gain_r <= '0;
      accum_mode_r    <= ACC_NONE;
      adapt_rate_r    <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_index_t'(cfg_ch.index))
        CFG_LEARN_RATE:    learn_rate_r    <= cfg_ch.data;
        CFG_BATCH_COUNT:   batch_count_r   <= cfg_ch.data;
        CFG_REG_STRENGTH:  reg_strength_r  <= cfg_ch.data;
        CFG_REG_MODE:      reg_mode_r      <= cfg_ch.data[1:0];
        CFG_MOMENTUM_GAIN: momentum_gain_r <= cfg_ch.data;
        CFG_ACCUM_MODE:    accum_mode_r    <= cfg_ch.data[1:0];
        CFG_ADAPT_RATE:    adapt_rate_r    <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // step = (learn_rate << 16) / batch, one quotient bit a cycle
  logic [4:0]  div_cnt_r;
  logic [15:0] div_rem_r, div_rem_nxt, div_den;
  logic [31:0] div_num_r, step_r;
  logic [16:0] div_trial;
  logic        div_bit;

  assign div_den     = (batch_count_r == '0) ? 16'd1 : batch_count_r;  // batch 0 acts as 1
  assign div_trial   = {div_rem_r, div_num_r[31]};
  assign div_bit     = div_trial >= {1'b0, div_den};
  assign div_rem_nxt = div_bit ? 16'(div_trial - {1'b0, div_den}) : div_trial[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_load_r <= 1'b0;
      div_run_r  <= 1'b0;
      div_cnt_r  <= '0;
      div_rem_r  <= '0;
      div_num_r  <= '0;
      step_r     <= STEP_RST;
    end else begin
      div_load_r <= cfg_fire;
      if (div_load_r) begin
        div_run_r <= 1'b1;
        div_cnt_r <= '0;
        div_rem_r <= '0;
        div_num_r <= {learn_rate_r, 16'h0000};
      end else if (div_run_r) begin
        div_rem_r <= div_rem_nxt;
        div_num_r <= {div_num_r[30:0], 1'b0};
        step_r    <= {step_r[30:0], div_bit};
        div_cnt_r <= div_cnt_r + 5'd1;
        if (div_cnt_r == 5'd31) begin
          div_run_r <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------- pipeline
  logic adv, in_fire;
  logic out_valid_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv && !cfg_busy;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // stage 1: magnitudes, grad square, momentum product
  logic [31:0] in_gmag, in_pgmag;
  logic [63:0] in_gsq;
  logic [47:0] in_momp;

  assign in_gmag  = in_ch.grad_sum[31] ? (~in_ch.grad_sum + 32'd1) : in_ch.grad_sum;
  assign in_pgmag = in_ch.prev_grad[31] ? (~in_ch.prev_grad + 32'd1) : in_ch.prev_grad;
  assign in_gsq   = in_gmag * in_gmag;
  assign in_momp  = in_pgmag * momentum_gain_r;

  logic        s1_v_r, s1_bias_r, s1_gneg_r, s1_pgneg_r, s1_last_r;
  logic [31:0] s1_w_r, s1_gmag_r, s1_acc_r;
  logic [63:0] s1_gsq_r;
  logic [47:0] s1_momp_r;

  // stage 2: saturated square, signed momentum
  logic        s2_v_r, s2_bias_r, s2_gneg_r, s2_last_r;
  logic [31:0] s2_w_r, s2_gmag_r, s2_acc_r, s2_sq_r;
  logic signed [32:0] s2_mom_r;
  logic [31:0] s1_sq;
  logic signed [32:0] s1_mom;

  assign s1_sq  = (|s1_gsq_r[63:32+F]) ? '1 : s1_gsq_r[31+F:F];
  assign s1_mom = s1_bias_r ? '0 :
                  (s1_pgneg_r ? -$signed({1'b0, s1_momp_r[47:16]})
                              :  $signed({1'b0, s1_momp_r[47:16]}));

  // stage 3: accumulator update
  logic        s3_v_r, s3_bias_r, s3_gneg_r, s3_last_r;
  logic [31:0] s3_w_r, s3_gmag_r, s3_acc_r;
  logic signed [32:0] s3_mom_r;
  logic [32:0] s2_ada_sum;
  logic [48:0] s2_rms_sum;
  logic [31:0] s2_acc_new;

  assign s2_ada_sum = {1'b0, s2_acc_r} + {1'b0, s2_sq_r};
  assign s2_rms_sum = ({17'd0, s2_acc_r} * {33'd0, RMS_KEEP})
                    + ({17'd0, s2_sq_r} * {33'd0, RMS_NEW});

  always_comb begin
    s2_acc_new = s2_acc_r;
    if (!s2_bias_r) begin
      case (accum_mode_t'(accum_mode_r))
        ACC_ADAGRAD: s2_acc_new = s2_ada_sum[32] ? '1 : s2_ada_sum[31:0];
        ACC_RMSPROP: s2_acc_new = s2_rms_sum[47:16];
        default:     s2_acc_new = s2_acc_r;  // none, and the unused code
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_fire;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_bias_r  <= in_ch.action;
      s1_w_r     <= in_ch.weight_value;
      s1_gneg_r  <= in_ch.grad_sum[31];
      s1_gmag_r  <= in_gmag;
      s1_pgneg_r <= in_ch.prev_grad[31];
      s1_gsq_r   <= in_gsq;
      s1_momp_r  <= in_momp;
      s1_acc_r   <= in_ch.sq_accum;
      s1_last_r  <= in_ch.last_element;

      s2_bias_r <= s1_bias_r;
      s2_w_r    <= s1_w_r;
      s2_gneg_r <= s1_gneg_r;
      s2_gmag_r <= s1_gmag_r;
      s2_acc_r  <= s1_acc_r;
      s2_sq_r   <= s1_sq;
      s2_mom_r  <= s1_mom;
      s2_last_r <= s1_last_r;

      s3_bias_r <= s2_bias_r;
      s3_w_r    <= s2_w_r;
      s3_gneg_r <= s2_gneg_r;
      s3_gmag_r <= s2_gmag_r;
      s3_acc_r  <= s2_acc_new;
      s3_mom_r  <= s2_mom_r;
      s3_last_r <= s2_last_r;
    end
  end

  // per-element rate: (step << F) / isqrt((acc + eps) << F)
  logic [32:0]   s3_acc_eps;
  logic [XW-1:0] rp_x;
  logic [DW-1:0] rp_n, rp_q;
  rp_sb_t        rp_sb_in, rp_sb_out;
  logic          rp_v;

  assign s3_acc_eps = {1'b0, s3_acc_r} + 33'(ADAPT_EPSILON);
  assign rp_x       = {{(XW-33){1'b0}}, s3_acc_eps} << F;
  assign rp_n       = {step_r, {F{1'b0}}};

  always_comb begin
    rp_sb_in.bias = s3_bias_r;
    rp_sb_in.w    = s3_w_r;
    rp_sb_in.gneg = s3_gneg_r;
    rp_sb_in.gmag = s3_gmag_r;
    rp_sb_in.mom  = s3_mom_r;
    rp_sb_in.acc  = s3_acc_r;
    rp_sb_in.last = s3_last_r;
  end

  sgdu_rate_pipe #(
    .XW   (XW),
    .DW   (DW),
    .SB_W ($bits(rp_sb_t))
  ) u_rate_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s3_v_r),
    .in_x      (rp_x),
    .in_n      (rp_n),
    .in_sb     (rp_sb_in),
    .out_valid (rp_v),
    .out_q     (rp_q),
    .out_sb    (rp_sb_out)
  );

  // stage 5: rate select; bias always takes the plain step
  logic              s5_v_r;
  rp_sb_t            s5_sb_r;
  logic [RATE_W-1:0] s5_rate_r;

  // stage 6: rate * lambda, grad * rate split in two halves
  logic              s6_v_r;
  rp_sb_t            s6_sb_r;
  logic [PRW-1:0]    s6_prl_r;
  logic [63:0]       s6_glo_r;
  logic [TW-1:0]     s6_ghi_r;

  // stage 7: grad term, L1 term, L2 products
  logic              s7_v_r;
  rp_sb_t            s7_sb_r;
  logic [TW-1:0]     s7_gterm_r;
  logic [L1W-1:0]    s7_l1_r;
  logic [63:0]       s7_wlo_r;
  logic [TW-1:0]     s7_whi_r;
  logic [31:0]       s6_wmag;
  logic [RATE_W-1:0] s6_r2;

  assign s6_wmag = s6_sb_r.w[31] ? (~s6_sb_r.w + 32'd1) : s6_sb_r.w;
  assign s6_r2   = s6_prl_r[PRW-1:16];

  // stage 8: signed partial sum and regularisation term
  logic              s8_v_r, s8_last_r;
  logic [31:0]       s8_acc_r;
  logic signed [SW-1:0] s8_part_r, s8_reg_r;
  logic [TW-1:0]     s7_l2;
  logic signed [SW-1:0] s7_gs, s7_ws, s7_ms, s7_l1s, s7_l2s, s7_reg;

  assign s7_l2  = s7_whi_r + {{HI_W{1'b0}}, s7_wlo_r[63:32]};
  assign s7_ws  = SW'($signed(s7_sb_r.w));
  assign s7_ms  = SW'(s7_sb_r.mom);
  assign s7_gs  = s7_sb_r.gneg ? -$signed({4'b0, s7_gterm_r}) : $signed({4'b0, s7_gterm_r});
  assign s7_l1s = $signed({{(SW-L1W){1'b0}}, s7_l1_r});
  assign s7_l2s = $signed({4'b0, s7_l2});

  always_comb begin
    s7_reg = '0;
    if (!s7_sb_r.bias) begin
      case (reg_mode_t'(reg_mode_r))
        REG_L1:  s7_reg = s7_sb_r.w[31] ? -s7_l1s : s7_l1s;  // sign of old weight, zero positive
        REG_L2:  s7_reg = s7_sb_r.w[31] ? -s7_l2s : s7_l2s;
        default: s7_reg = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= rp_v;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sb_r   <= rp_sb_out;
      s5_rate_r <= (adapt_rate_r && !rp_sb_out.bias) ? rp_q[RATE_W-1:0]
                                                     : {{HI_W{1'b0}}, step_r};

      s6_sb_r  <= s5_sb_r;
      s6_prl_r <= s5_rate_r * reg_strength_r;
      s6_glo_r <= s5_sb_r.gmag * s5_rate_r[31:0];
      s6_ghi_r <= s5_sb_r.gmag * s5_rate_r[RATE_W-1:32];

      s7_sb_r    <= s6_sb_r;
      s7_gterm_r <= s6_ghi_r + {{HI_W{1'b0}}, s6_glo_r[63:32]};
      s7_l1_r    <= s6_prl_r[PRW-1:48-F];
      s7_wlo_r   <= s6_wmag * s6_r2[31:0];
      s7_whi_r   <= s6_wmag * s6_r2[RATE_W-1:32];

      s8_last_r <= s7_sb_r.last;
      s8_acc_r  <= s7_sb_r.acc;
      s8_part_r <= s7_ws - s7_gs - s7_ms;
      s8_reg_r  <= s7_reg;
    end
  end

  // output register: final subtract and int32 saturation
  logic signed [SW-1:0] s8_res;
  logic [31:0]          s8_sat;
  logic signed [31:0]   out_new_value_r;
  logic [31:0]          out_new_sq_accum_r;
  logic                 out_last_r;

  assign s8_res = s8_part_r - s8_reg_r;

  always_comb begin
    if ((&s8_res[SW-1:31]) || !(|s8_res[SW-1:31])) begin
      s8_sat = s8_res[31:0];
    end else if (s8_res[SW-1]) begin
      s8_sat = 32'h8000_0000;
    end else begin
      s8_sat = 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_new_value_r    <= s8_sat;
      out_new_sq_accum_r <= s8_acc_r;
      out_last_r         <= s8_last_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.new_value    = out_new_value_r;
  assign out_ch.new_sq_accum = out_new_sq_accum_r;
  assign out_ch.last_out     = out_last_r;

endmodule
